@@ rtl/vstr_pkg.sv @@
// Package for the visual servo thruster regulator.
// Holds widths, register indexes, state codes and the arithmetic helpers.
// No dependencies.
package vstr_pkg;

  localparam int PIXEL_BITS_DEF = 12;
  localparam int GAIN_W = 16;
  localparam int ACC_W  = 32;
  localparam int MUL_AW = 17;
  localparam int MUL_BW = 33;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int UW     = 56;   // controller sum, Q.24
  localparam int QB     = 17;   // quotient bits from the divider
  localparam int NORM_SH = 9;
  localparam int LIFT_SH = 16;
  localparam int RES_W  = 16;
  // reciprocal of five, ceil(2^22 / 5): exact floor divide below 2^22
  localparam int DIV5_SH  = 22;
  localparam int DIV5_MUL = 838861;

  typedef enum logic [2:0] {
    REG_SURGE_KP = 3'd0,
    REG_SURGE_KI = 3'd1,
    REG_SURGE_KD = 3'd2,
    REG_YAW_KP   = 3'd3,
    REG_YAW_KI   = 3'd4,
    REG_HEAVE_KP = 3'd5,
    REG_HEAVE_KI = 3'd6,
    REG_TIME_STEP = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ESTART,
    ST_MUL,
    ST_NSTART,
    ST_NWAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_stat_t;

  // accumulator plus product, clamped to 32-bit signed
  function automatic logic signed [ACC_W-1:0] sat_acc(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [MUL_PW-1:0] p
  );
    logic signed [MUL_PW:0] s;
    s = (MUL_PW+1)'(acc) + (MUL_PW+1)'(p);
    if (s > (MUL_PW+1)'(signed'(32'sh7FFFFFFF))) begin
      sat_acc = 32'sh7FFFFFFF;
    end else if (s < (MUL_PW+1)'(signed'(32'sh80000000))) begin
      sat_acc = 32'sh80000000;
    end else begin
      sat_acc = ACC_W'(s);
    end
  endfunction

  // signed Q1.15 result from sign, saturation and quotient magnitude
  function automatic logic signed [RES_W-1:0] finish(
    input logic zero,
    input logic neg,
    input logic sat,
    input logic [QB-1:0] mag
  );
    if (zero) begin
      finish = '0;
    end else if (sat) begin
      finish = neg ? 16'sh8000 : 16'sh7FFF;
    end else if (neg) begin
      finish = (mag > QB'(32768)) ? 16'sh8000 : RES_W'(-$signed({1'b0, mag}));
    end else begin
      finish = (mag > QB'(32767)) ? 16'sh7FFF : RES_W'(mag);
    end
  endfunction

endpackage

@@ rtl/vstr_mul.sv @@
// Shared signed multiplier with registered product.
// Depends on vstr_pkg for operand widths.
module vstr_mul (
  input  logic                                  clk,
  input  logic signed [vstr_pkg::MUL_AW-1:0]    a,
  input  logic signed [vstr_pkg::MUL_BW-1:0]    b,
  output logic signed [vstr_pkg::MUL_PW-1:0]    p_r
);

  // one product per cycle
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

@@ rtl/vstr_div.sv @@
// Restoring divider, one quotient bit per cycle, with overflow detect.
// Depends on vstr_pkg for the status struct.
module vstr_div #(
  parameter int NW = 56,
  parameter int DW = 22,
  parameter int QBITS = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NW-1:0]        num,
  input  logic [DW-1:0]        den,
  output vstr_pkg::div_stat_t  stat,
  output logic [QBITS-1:0]     q
);

  localparam int HW = NW - QBITS;
  localparam int CW = $clog2(QBITS + 1);

  logic             busy_r, done_r, ovf_r;
  logic [CW-1:0]    cnt_r;
  logic [DW-1:0]    rem_r, den_r;
  logic [QBITS-1:0] low_r, q_r;
  logic [DW:0]      trial;
  logic             ge;
  logic             hi_ovf;

  assign hi_ovf = num[NW-1:QBITS] >= {{(HW-DW){1'b0}}, den};
  assign trial  = {rem_r, low_r[QBITS-1]};
  assign ge     = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ovf_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ovf_r <= hi_ovf;
        if (hi_ovf) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CW'(QBITS);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= DW'(num[NW-1:QBITS]);
      low_r <= num[QBITS-1:0];
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      low_r <= {low_r[QBITS-2:0], 1'b0};
      q_r   <= {q_r[QBITS-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign q = q_r;

endmodule

@@ rtl/visual_servo_thruster_regulator.sv @@
// Visual servo thruster regulator: one detection item in, one set of surge,
// heave and yaw setpoints out. An item is taken only while the block is idle,
// and its steps run in order: the size error (a reciprocal multiply does the
// divide by five), the ten products through the one shared multiplier,
// three 17-bit restoring divisions for the normalization, and the load of
// the output register. A zero divisor skips its division and a quotient
// overflow ends it without the quotient steps. in_ready is high only while
// no item is in work; a finished result sits in the output register, so the
// next item may enter while it waits, and a second finished result stalls
// until the first one is taken.
module visual_servo_thruster_regulator #(
  parameter int PIXEL_BITS = vstr_pkg::PIXEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_idx,
  input  logic [15:0]             cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIXEL_BITS-1:0]   in_frame_center_x,
  input  logic [PIXEL_BITS-1:0]   in_frame_center_y,
  input  logic [PIXEL_BITS-1:0]   in_box_center_x,
  input  logic [PIXEL_BITS-1:0]   in_box_center_y,
  input  logic [PIXEL_BITS-1:0]   in_frame_width,
  input  logic [PIXEL_BITS-1:0]   in_frame_height,
  input  logic [PIXEL_BITS-1:0]   in_box_width,
  input  logic [PIXEL_BITS-1:0]   in_box_height,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [15:0]      out_surge_setpoint,
  output logic signed [15:0]      out_heave_setpoint,
  output logic signed [15:0]      out_yaw_setpoint,
  output logic                    out_divide_fault
);

  localparam int P  = PIXEL_BITS;
  localparam int SW = P + 1;               // size sums
  localparam int EW = P + 3;               // surge error
  localparam int DW = P + 1 + vstr_pkg::NORM_SH;
  localparam int UW = vstr_pkg::UW;
  localparam int QB = vstr_pkg::QB;
  localparam int AW = vstr_pkg::MUL_AW;
  localparam int BW = vstr_pkg::MUL_BW;
  localparam int PW = vstr_pkg::MUL_PW;
  localparam int GW = vstr_pkg::GAIN_W;
  localparam int CW = vstr_pkg::ACC_W;
  localparam int RW = vstr_pkg::RES_W;
  localparam int LAST_STEP = 10;

  vstr_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic signed [GW-1:0] kp_s_r, ki_s_r, kd_s_r, kp_x_r, ki_x_r, kp_y_r, ki_y_r;
  logic [GW-1:0]        ts_r;

  // item and working registers
  logic [P-1:0]          fcx_r, fcy_r;
  logic [SW-1:0]         fsize_r, bsum_r;
  logic signed [SW:0]    ex_r, ey_r;
  logic signed [EW-1:0]  err_r, prev_r;
  logic signed [EW:0]    derr_r;
  logic signed [CW-1:0]  acc_s_r, acc_x_r, acc_y_r;
  logic signed [UW-1:0]  u_s_r, u_x_r, u_y_r;
  logic [3:0]            step_r;
  logic [1:0]            ch_r;
  logic                  fault_r;
  logic signed [RW-1:0]  res_s_r, res_y_r, res_x_r;
  logic                  out_valid_r;
  logic signed [RW-1:0]  out_s_r, out_y_r, out_x_r;
  logic                  out_f_r;

  logic                  in_acc, out_load;
  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [UW-1:0]  p_ext;
  logic                  div_start;
  logic [UW-1:0]         div_num;
  logic [DW-1:0]         div_den;
  vstr_pkg::div_stat_t   div_stat;
  logic [QB-1:0]         div_q;
  logic [P+2:0]          size3;
  logic [P+23:0]         size_prod;
  logic [P+1:0]          size_q;
  logic signed [EW-1:0]  err_new;
  logic signed [UW-1:0]  u_cur;
  logic [P+1:0]          den_base;
  logic                  u_neg, res_neg;
  logic signed [RW-1:0]  res_val;

  assign in_acc = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vstr_pkg::ST_IDLE:   if (in_valid) state_nxt = vstr_pkg::ST_ESTART;
      vstr_pkg::ST_ESTART: state_nxt = vstr_pkg::ST_MUL;
      vstr_pkg::ST_MUL:    if (step_r == 4'(LAST_STEP)) state_nxt = vstr_pkg::ST_NSTART;
      vstr_pkg::ST_NSTART: begin
        if (den_base == '0) begin
          state_nxt = (ch_r == 2'd2) ? vstr_pkg::ST_OUT : vstr_pkg::ST_NSTART;
        end else begin
          state_nxt = vstr_pkg::ST_NWAIT;
        end
      end
      vstr_pkg::ST_NWAIT: begin
        if (div_stat.done) begin
          state_nxt = (ch_r == 2'd2) ? vstr_pkg::ST_OUT : vstr_pkg::ST_NSTART;
        end
      end
      vstr_pkg::ST_OUT:    if (!out_valid_r || out_ready) state_nxt = vstr_pkg::ST_IDLE;
      default:             state_nxt = vstr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      vstr_pkg::ST_IDLE:   in_ready = 1'b1;
      vstr_pkg::ST_NSTART: div_start = (den_base != '0);
      vstr_pkg::ST_OUT:    out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vstr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_s_r <= '0; ki_s_r <= '0; kd_s_r <= '0;
      kp_x_r <= '0; ki_x_r <= '0; kp_y_r <= '0; ki_y_r <= '0;
      ts_r   <= GW'(6554);
    end else if (cfg_we) begin
      unique case (vstr_pkg::cfg_idx_t'(cfg_idx))
        vstr_pkg::REG_SURGE_KP:  kp_s_r <= cfg_wdata;
        vstr_pkg::REG_SURGE_KI:  ki_s_r <= cfg_wdata;
        vstr_pkg::REG_SURGE_KD:  kd_s_r <= cfg_wdata;
        vstr_pkg::REG_YAW_KP:    kp_x_r <= cfg_wdata;
        vstr_pkg::REG_YAW_KI:    ki_x_r <= cfg_wdata;
        vstr_pkg::REG_HEAVE_KP:  kp_y_r <= cfg_wdata;
        vstr_pkg::REG_HEAVE_KI:  ki_y_r <= cfg_wdata;
        vstr_pkg::REG_TIME_STEP: ts_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      4'd0: begin mul_a = $signed({1'b0, ts_r}); mul_b = BW'(err_r); end
      4'd1: begin mul_a = $signed({1'b0, ts_r}); mul_b = BW'(ex_r); end
      4'd2: begin mul_a = $signed({1'b0, ts_r}); mul_b = BW'(ey_r); end
      4'd3: begin mul_a = AW'(kp_s_r); mul_b = BW'(err_r); end
      4'd4: begin mul_a = AW'(kd_s_r); mul_b = BW'(derr_r); end
      4'd5: begin mul_a = AW'(ki_s_r); mul_b = BW'(acc_s_r); end
      4'd6: begin mul_a = AW'(kp_x_r); mul_b = BW'(ex_r); end
      4'd7: begin mul_a = AW'(ki_x_r); mul_b = BW'(acc_x_r); end
      4'd8: begin mul_a = AW'(kp_y_r); mul_b = BW'(ey_r); end
      4'd9: begin mul_a = AW'(ki_y_r); mul_b = BW'(acc_y_r); end
      default: ;
    endcase
  end

  vstr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign p_ext = UW'(mul_p);

  // size error: (3*S + 2) / 5 through a constant reciprocal multiply
  assign size3     = (P+3)'(fsize_r) * (P+3)'(3) + (P+3)'(2);
  assign size_prod = (P+24)'(size3) * (P+24)'(vstr_pkg::DIV5_MUL);
  assign size_q    = size_prod[vstr_pkg::DIV5_SH +: P+2];

  // divider operands for the three normalizations
  always_comb begin
    den_base = '0;
    u_cur    = u_s_r;
    unique case (ch_r)
      2'd0: begin den_base = (P+2)'(fsize_r); u_cur = u_s_r; end
      2'd1: begin den_base = (P+2)'(fcy_r);   u_cur = u_y_r; end
      2'd2: begin den_base = (P+2)'(fcx_r);   u_cur = u_x_r; end
      default: ;
    endcase
    div_num = u_cur[UW-1] ? UW'(-u_cur) : UW'(u_cur);
    div_den = {den_base[SW-1:0], {vstr_pkg::NORM_SH{1'b0}}};
  end

  vstr_div #(.NW(UW), .DW(DW), .QBITS(QB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .q     (div_q)
  );

  assign err_new = $signed(EW'(size_q)) - $signed(EW'(bsum_r));
  assign u_neg   = u_cur[UW-1];
  assign res_neg = u_neg ^ (ch_r == 2'd2);
  assign res_val = vstr_pkg::finish(u_cur == '0, res_neg,
                                    (den_base == '0) || div_stat.ovf, div_q);

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      acc_s_r <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
      step_r  <= '0;
      ch_r    <= '0;
      fault_r <= 1'b0;
    end else begin
      if (in_acc) begin
        fcx_r   <= in_frame_center_x;
        fcy_r   <= in_frame_center_y;
        fsize_r <= SW'(in_frame_width) + SW'(in_frame_height);
        bsum_r  <= SW'(in_box_width) + SW'(in_box_height);
        ex_r    <= $signed({2'b0, in_frame_center_x}) - $signed({2'b0, in_box_center_x});
        ey_r    <= $signed({2'b0, in_frame_center_y}) - $signed({2'b0, in_box_center_y});
        fault_r <= 1'b0;
        step_r  <= '0;
        ch_r    <= '0;
      end
      // size error ready
      if (state_r == vstr_pkg::ST_ESTART) begin
        err_r  <= err_new;
        derr_r <= (EW+1)'(err_new) - (EW+1)'(prev_r);
        prev_r <= err_new;
        u_s_r  <= '0;
        u_x_r  <= '0;
        u_y_r  <= '0;
      end
      // product issue and consume
      if (state_r == vstr_pkg::ST_MUL) begin
        step_r <= step_r + 4'd1;
        unique case (step_r)
          4'd1:  acc_s_r <= vstr_pkg::sat_acc(acc_s_r, mul_p);
          4'd2:  acc_x_r <= vstr_pkg::sat_acc(acc_x_r, mul_p);
          4'd3:  acc_y_r <= vstr_pkg::sat_acc(acc_y_r, mul_p);
          4'd4,
          4'd5:  u_s_r <= u_s_r + (p_ext <<< vstr_pkg::LIFT_SH);
          4'd6:  u_s_r <= u_s_r + p_ext;
          4'd7:  u_x_r <= u_x_r + (p_ext <<< vstr_pkg::LIFT_SH);
          4'd8:  u_x_r <= u_x_r + p_ext;
          4'd9:  u_y_r <= u_y_r + (p_ext <<< vstr_pkg::LIFT_SH);
          4'd10: u_y_r <= u_y_r + p_ext;
          default: ;
        endcase
      end
      // normalization results
      if ((state_r == vstr_pkg::ST_NSTART && den_base == '0) ||
          (state_r == vstr_pkg::ST_NWAIT && div_stat.done)) begin
        if (den_base == '0) fault_r <= 1'b1;
        unique case (ch_r)
          2'd0:    res_s_r <= res_val;
          2'd1:    res_y_r <= res_val;
          default: res_x_r <= res_val;
        endcase
        ch_r <= ch_r + 2'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_s_r <= res_s_r;
      out_y_r <= res_y_r;
      out_x_r <= res_x_r;
      out_f_r <= fault_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_surge_setpoint = out_s_r;
  assign out_heave_setpoint = out_y_r;
  assign out_yaw_setpoint   = out_x_r;
  assign out_divide_fault   = out_f_r;

  // divider never restarted while busy
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy) else $error("divider started while busy");

  // an accepted item starts the size-error step
  a_item_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == vstr_pkg::ST_ESTART) else $error("item not started");

  // a zero divisor always raises the fault flag
  a_zero_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vstr_pkg::ST_NSTART && den_base == '0) |=> fault_r)
    else $error("zero divisor without fault");

endmodule

@@ tb/sv/vstr_checker.sv @@
// Checker for the visual servo thruster regulator: watches both channels,
// predicts the setpoints of every accepted item and compares them.
// Depends on vstr_pkg for the register index codes.
`timescale 1ns / 1ps
module vstr_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [11:0]        in_fcx,
  input  logic [11:0]        in_fcy,
  input  logic [11:0]        in_bcx,
  input  logic [11:0]        in_bcy,
  input  logic [11:0]        in_fw,
  input  logic [11:0]        in_fh,
  input  logic [11:0]        in_bw,
  input  logic [11:0]        in_bh,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_surge,
  input  logic signed [15:0] out_heave,
  input  logic signed [15:0] out_yaw,
  input  logic               out_fault,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count,
  output int                 fault_count
);

  typedef struct packed {
    logic signed [15:0] surge;
    logic signed [15:0] heave;
    logic signed [15:0] yaw;
    logic               fault;
  } setpoints_t;

  setpoints_t setpoint_queue[$];

  // controller gains and loop state
  logic signed [15:0] kp_s, ki_s, kd_s, kp_y, ki_y, kp_h, ki_h;
  logic [15:0] dt;
  longint prev_err, acc_s, acc_y, acc_h;

  function automatic longint integrate(longint acc, longint err, logic [15:0] step);
    longint s;
    s = acc + err * longint'(step);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  function automatic logic signed [15:0] scale_q15(longint u, longint div, logic neg,
                                                   inout logic flt);
    longint q;
    if (div == 0) begin
      flt = 1'b1;
      q = (u > 0) ? 40000 : ((u < 0) ? -40000 : 0);
    end else begin
      q = u / (div * 512);
    end
    if (neg) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  always @(posedge clk) begin
    setpoints_t exp_sp, got;
    longint fsz, err, derr, ex, ey, us, ux, uy;
    logic flt;
    if (!rst_n) begin
      kp_s <= '0; ki_s <= '0; kd_s <= '0; kp_y <= '0; ki_y <= '0;
      kp_h <= '0; ki_h <= '0; dt <= 16'd6554;
      prev_err = 0; acc_s = 0; acc_y = 0; acc_h = 0;
      setpoint_queue.delete();
      fail_count <= 0; result_count <= 0; fault_count <= 0;
    end else begin
      if (cfg_we) begin
        case (vstr_pkg::cfg_idx_t'(cfg_idx))
          vstr_pkg::REG_SURGE_KP:  kp_s <= cfg_wdata;
          vstr_pkg::REG_SURGE_KI:  ki_s <= cfg_wdata;
          vstr_pkg::REG_SURGE_KD:  kd_s <= cfg_wdata;
          vstr_pkg::REG_YAW_KP:    kp_y <= cfg_wdata;
          vstr_pkg::REG_YAW_KI:    ki_y <= cfg_wdata;
          vstr_pkg::REG_HEAVE_KP:  kp_h <= cfg_wdata;
          vstr_pkg::REG_HEAVE_KI:  ki_h <= cfg_wdata;
          vstr_pkg::REG_TIME_STEP: dt <= cfg_wdata;
          default: ;
        endcase
      end
      // predict on item acceptance
      if (in_valid && in_ready) begin
        flt = 1'b0;
        fsz = longint'(in_fw) + longint'(in_fh);
        err = (6 * fsz + 5) / 10 - (longint'(in_bw) + longint'(in_bh));
        derr = err - prev_err;
        prev_err = err;
        acc_s = integrate(acc_s, err, dt);
        ex = longint'(in_fcx) - longint'(in_bcx);
        ey = longint'(in_fcy) - longint'(in_bcy);
        acc_y = integrate(acc_y, ex, dt);
        acc_h = integrate(acc_h, ey, dt);
        us = longint'(kp_s) * err * 65536 + longint'(ki_s) * acc_s
           + longint'(kd_s) * derr * 65536;
        ux = longint'(kp_y) * ex * 65536 + longint'(ki_y) * acc_y;
        uy = longint'(kp_h) * ey * 65536 + longint'(ki_h) * acc_h;
        exp_sp.surge = scale_q15(us, fsz, 1'b0, flt);
        exp_sp.heave = scale_q15(uy, longint'(in_fcy), 1'b0, flt);
        exp_sp.yaw = scale_q15(ux, longint'(in_fcx), 1'b1, flt);
        exp_sp.fault = flt;
        setpoint_queue.push_back(exp_sp);
      end
      // compare each result with the oldest expectation
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (out_fault) fault_count <= fault_count + 1;
        if (setpoint_queue.size() == 0) begin
          $error("unexpected result item");
          fail_count <= fail_count + 1;
        end else begin
          exp_sp = setpoint_queue.pop_front();
          got = '{out_surge, out_heave, out_yaw, out_fault};
          if (got != exp_sp) fail_count <= fail_count + 1;
          if (got.surge != exp_sp.surge)
            $error("surge_setpoint: expected %0d, got %0d", exp_sp.surge, got.surge);
          if (got.heave != exp_sp.heave)
            $error("heave_setpoint: expected %0d, got %0d", exp_sp.heave, got.heave);
          if (got.yaw != exp_sp.yaw)
            $error("yaw_setpoint: expected %0d, got %0d", exp_sp.yaw, got.yaw);
          if (got.fault != exp_sp.fault)
            $error("divide_fault: expected %0d, got %0d", exp_sp.fault, got.fault);
        end
      end
    end
    pending_count <= setpoint_queue.size();
  end
endmodule

@@ tb/sv/visual_servo_thruster_regulator_tb.sv @@
// Top of the regulator testbench: clock, reset, register phases, detection
// stimulus, output back-pressure and the verdict. Depends on vstr_pkg,
// vstr_checker and the regulator RTL.
`timescale 1ns / 1ps
module visual_servo_thruster_regulator_tb;

  localparam int IDLE_LIMIT = 20000;

  logic clk, rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [15:0] cfg_wdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [11:0] fcx, fcy, bcx, bcy, fw, fh, bw, bh;
  logic signed [15:0] surge, heave, yaw;
  logic fault;
  int fail_count, pending_count, result_count, fault_count;
  int item_count;
  logic rx_idle_on, rx_hold;

  visual_servo_thruster_regulator uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_frame_center_x(fcx), .in_frame_center_y(fcy),
    .in_box_center_x(bcx), .in_box_center_y(bcy),
    .in_frame_width(fw), .in_frame_height(fh),
    .in_box_width(bw), .in_box_height(bh),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_surge_setpoint(surge), .out_heave_setpoint(heave),
    .out_yaw_setpoint(yaw), .out_divide_fault(fault)
  );

  vstr_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
    .in_fcx(fcx), .in_fcy(fcy), .in_bcx(bcx), .in_bcy(bcy),
    .in_fw(fw), .in_fh(fh), .in_bw(bw), .in_bh(bh),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_surge(surge), .out_heave(heave), .out_yaw(yaw), .out_fault(fault),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count), .fault_count(fault_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: cycles without any handshake
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("visual_servo_thruster_regulator_tb: FAIL");
        $finish;
      end
    end
  end

  // receiver: random stalls, long hold when asked, no stalls when idling is off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) out_ready <= 1'b0;
      else if (rx_idle_on) out_ready <= ($urandom_range(99) >= 12);
      else out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input vstr_pkg::cfg_idx_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drop valid, wait until all expected setpoints have arrived, then settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0 || in_valid) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  // valid stays high from one item to the next unless an idle gap is drawn
  task automatic send_frame(input logic [11:0] a, b, c, d, e, f, g, h,
                            input logic gaps);
    @(negedge clk);
    if (gaps) begin
      while ($urandom_range(99) < 12) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    {fcx, fcy, bcx, bcy} <= {a, b, c, d};
    {fw, fh, bw, bh} <= {e, f, g, h};
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    item_count++;
  endtask

  function automatic logic [11:0] pix();
    case ($urandom_range(9))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return 12'($urandom_range(15));
      default: return 12'($urandom);
    endcase
  endfunction

  // a plausible detection: box center within twice the frame center, box no larger than the frame
  task automatic send_plausible(input logic gaps);
    logic [11:0] w, h, cx, cy;
    w = 12'($urandom_range(4095, 16));
    h = 12'($urandom_range(4095, 16));
    cx = 12'($urandom_range(2047, 1));
    cy = 12'($urandom_range(2047, 1));
    send_frame(cx, cy, 12'($urandom_range(2 * cx)), 12'($urandom_range(2 * cy)),
               w, h, 12'($urandom_range(w)), 12'($urandom_range(h)), gaps);
  endtask

  task automatic random_gains();
    for (int r = 0; r < 7; r++) begin
      case ($urandom_range(5))
        0: write_reg(vstr_pkg::cfg_idx_t'(r), 16'h8000);
        1: write_reg(vstr_pkg::cfg_idx_t'(r), 16'h7FFF);
        2: write_reg(vstr_pkg::cfg_idx_t'(r), 16'($urandom_range(512)));
        default: write_reg(vstr_pkg::cfg_idx_t'(r), 16'($urandom));
      endcase
    end
    case ($urandom_range(3))
      0: write_reg(vstr_pkg::REG_TIME_STEP, 16'h0001);
      1: write_reg(vstr_pkg::REG_TIME_STEP, 16'hFFFF);
      default: write_reg(vstr_pkg::REG_TIME_STEP, 16'($urandom));
    endcase
  endtask

  initial begin
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    in_valid = 1'b0;
    {fcx, fcy, bcx, bcy, fw, fh, bw, bh} = '0;
    rx_idle_on = 1'b1; rx_hold = 1'b0;
    item_count = 0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset gains first, then unit gains
    send_frame(12'd100, 12'd100, 12'd90, 12'd110, 12'd640, 12'd480, 12'd50, 12'd60, 0);
    drain_results();
    for (int r = 0; r < 7; r++) write_reg(vstr_pkg::cfg_idx_t'(r), 16'h0100);
    write_reg(vstr_pkg::REG_TIME_STEP, 16'd6554);
    // zero divisors, all-zero and all-ones frames, rounding ties
    send_frame(12'd0, 12'd0, 12'd5, 12'd7, 12'd0, 12'd0, 12'd3, 12'd4, 0);
    send_frame(12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 0);
    send_frame('1, '1, '1, '1, '1, '1, '1, '1, 0);
    send_frame('1, '1, 12'd0, 12'd0, '1, '1, 12'd0, 12'd0, 0);
    send_frame(12'd1, 12'd1, '1, '1, 12'd0, 12'd0, '1, '1, 0);
    send_frame(12'd320, 12'd0, 12'd300, 12'd10, 12'd5, 12'd0, 12'd1, 12'd1, 0);
    send_frame(12'd0, 12'd240, 12'd10, 12'd200, 12'd4, 12'd1, 12'd0, 12'd0, 0);
    send_frame(12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'hAAA, 12'h555, 12'h555, 12'hAAA, 0);
    drain_results();
    // extreme gains and step drive the accumulators into saturation
    for (int r = 0; r < 7; r++) write_reg(vstr_pkg::cfg_idx_t'(r), 16'h7FFF);
    write_reg(vstr_pkg::REG_TIME_STEP, 16'hFFFF);
    for (int i = 0; i < 6; i++)
      send_frame('1, '1, 12'd0, 12'd0, '1, '1, 12'd0, 12'd0, 0);
    for (int i = 0; i < 6; i++)
      send_frame(12'd1, 12'd1, '1, '1, 12'd1, 12'd0, '1, '1, 0);
    drain_results();
    for (int r = 0; r < 7; r++) write_reg(vstr_pkg::cfg_idx_t'(r), 16'h8000);
    write_reg(vstr_pkg::REG_TIME_STEP, 16'd0);
    send_frame(12'd7, 12'd9, 12'd100, 12'd3, 12'd200, 12'd100, 12'd10, 12'd20, 0);
    send_frame(12'd900, 12'd9, 12'd1, 12'd3, 12'd20, 12'd10, 12'd100, 12'd200, 0);
    drain_results();

    // random phases with new settings each time
    for (int ph = 0; ph < 10; ph++) begin
      random_gains();
      if (ph == 3) begin
        // receiver holds off while items keep coming
        rx_hold = 1'b1;
        fork
          begin
            repeat (400) @(posedge clk);
            rx_hold = 1'b0;
          end
          for (int i = 0; i < 6; i++) send_plausible(0);
        join
      end
      rx_idle_on = (ph != 5);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(99) < 80) send_plausible(ph != 5);
        else send_frame(pix(), pix(), pix(), pix(), pix(), pix(), pix(), pix(), ph != 5);
      end
      // sender pauses until all results are back
      drain_results();
    end
    rx_idle_on = 1'b1;

    $display("covered %0d items, %0d results, %0d with divide fault, 10 gain settings",
             item_count, result_count, fault_count);
    if (fail_count == 0) $display("visual_servo_thruster_regulator_tb: PASS");
    else $display("visual_servo_thruster_regulator_tb: FAIL");
    $finish;
  end
endmodule
